[design/multithread_issue_scheduler_core_defines.svh]
// Assertion macros shared by the scheduler's checker.
// Plain text macros only; no dependencies.
`ifndef MULTITHREAD_ISSUE_SCHEDULER_CORE_DEFINES_SVH
`define MULTITHREAD_ISSUE_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication, reset masks the check.
`define MIS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, reset masks the check.
`define MIS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/mis_pkg.sv]
// Shared types and constants for the multithread issue scheduler.
// No dependencies; imported by every module of the block.
package mis_pkg;

  localparam int MAX_THREADS_DEF = 8;
  localparam int COUNT_WIDTH_DEF = 32;

  localparam int KIND_W         = 2;
  localparam int IN_TDATA_W     = 8;
  localparam int THREAD_FIELD_W = 3;
  localparam int FIELD_W        = 32;
  localparam int OUT_TDATA_W    = 104;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 8;

  localparam logic MODE_FINE = 1'b1;

  typedef enum logic [1:0] {
    KIND_ALU   = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_STORE = 2'd2,
    KIND_HALT  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MODE           = 3'd0,
    CFG_THREAD_COUNT   = 3'd1,
    CFG_SWITCH_PENALTY = 3'd2,
    CFG_LOAD_LATENCY   = 3'd3,
    CFG_STORE_LATENCY  = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [3:0] thread_count;
    logic [7:0] switch_penalty;
    logic [7:0] load_latency;
    logic [7:0] store_latency;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic apply;
    logic pick;
    logic commit;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

[design/mis_ctrl.sv]
// Step sequencer of the issue scheduler: accept, apply, pick, commit.
// Depends on mis_pkg for the command and status structs.
module mis_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mis_pkg::sts_t sts_i,
  output mis_pkg::cmd_t cmd_o
);
  import mis_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_APPLY,
    S_PICK,
    S_COMMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_APPLY;
      S_APPLY:  state_d = S_PICK;
      S_PICK:   state_d = S_COMMIT;
      S_COMMIT: if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign cmd_o.load    = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.apply   = (state_q == S_APPLY);
  assign cmd_o.pick    = (state_q == S_PICK);
  // hold in commit until the output register can take the beat
  assign cmd_o.commit  = (state_q == S_COMMIT) && sts_i.out_free;

endmodule

[design/mis_dp.sv]
// Datapath of the issue scheduler: per-thread ready times, halt flags and
// PCs, cycle and issue counters, rotate pick and the output register.
// Depends on mis_pkg; driven by mis_ctrl commands.
module mis_dp #(
  parameter int MAX_THREADS = mis_pkg::MAX_THREADS_DEF,
  parameter int COUNT_WIDTH = mis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mis_pkg::cfg_t                    cfg_i,
  input  mis_pkg::cmd_t                    cmd_i,
  output mis_pkg::sts_t                    sts_o,
  input  logic [mis_pkg::KIND_W-1:0]       kind_i,
  input  logic                             out_ready_i,
  output logic                             out_valid_o,
  output logic                             out_user_o,
  output logic [mis_pkg::OUT_TDATA_W-1:0]  out_data_o
);
  import mis_pkg::*;

  localparam int TW = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
  localparam int NW = $clog2(MAX_THREADS + 1);
  localparam int SW = TW + 1;
  localparam int PAD_W = OUT_TDATA_W - (THREAD_FIELD_W + 3 * FIELD_W + 1);

  logic [COUNT_WIDTH-1:0] ready_q [MAX_THREADS];
  logic [FIELD_W-1:0]     pc_q    [MAX_THREADS];
  logic [MAX_THREADS-1:0] halted_q;
  logic [TW-1:0]          active_q;
  logic [COUNT_WIDTH-1:0] cycle_q;
  logic [COUNT_WIDTH-1:0] issue_cnt_q;
  logic                   issued_q;
  logic                   sw_pend_q;
  logic                   started_q;
  kind_e                  kind_q;
  logic [TW-1:0]          next_q, next_d;
  logic                   next_vld_q, next_vld_d;
  logic                   out_valid_q;
  logic                   out_user_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic [NW-1:0]          n_eff;
  logic [MAX_THREADS-1:0] in_use;
  logic [MAX_THREADS-1:0] elig;
  logic                   all_halted;
  logic                   prev_idle;
  logic [SW-1:0]          start_raw;
  logic [SW-1:0]          start_c;
  logic [MAX_THREADS-1:0] upper;
  logic [TW-1:0]          pick_idx;
  logic                   pick_found;
  logic                   do_pen;
  logic [COUNT_WIDTH-1:0] cycle_pen;

  // clamp thread count into 1..MAX_THREADS
  always_comb begin
    if (cfg_i.thread_count == 4'd0) begin
      n_eff = NW'(1);
    end else if ({1'b0, cfg_i.thread_count} > 5'(MAX_THREADS)) begin
      n_eff = NW'(MAX_THREADS);
    end else begin
      n_eff = NW'(cfg_i.thread_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_THREADS; i++) begin
      in_use[i] = NW'(i) < n_eff;
      elig[i]   = in_use[i] && !halted_q[i] && (ready_q[i] <= cycle_q);
    end
  end

  assign all_halted = &(halted_q | ~in_use);
  assign prev_idle  = started_q && !issued_q;

  // blocked reselection after an idle step starts at the current thread
  assign start_raw = (cfg_i.mode != MODE_FINE && prev_idle) ? {1'b0, active_q}
                                                           : {1'b0, active_q} + SW'(1);
  assign start_c   = (start_raw >= SW'(n_eff)) ? '0 : start_raw;

  always_comb begin
    pick_idx   = '0;
    pick_found = 1'b0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      upper[i] = elig[i] && (SW'(i) >= start_c);
    end
    // lowest eligible at or above the start, else lowest eligible overall
    for (int i = MAX_THREADS - 1; i >= 0; i--) begin
      if (upper[i]) begin
        pick_idx   = TW'(i);
        pick_found = 1'b1;
      end
    end
    if (!pick_found) begin
      for (int i = MAX_THREADS - 1; i >= 0; i--) begin
        if (elig[i]) begin
          pick_idx   = TW'(i);
          pick_found = 1'b1;
        end
      end
    end
  end

  always_comb begin
    next_d     = active_q;
    next_vld_d = 1'b1;
    if (!started_q) begin
      next_d = '0;
    end else if (all_halted) begin
      next_vld_d = 1'b0;
    end else if (cfg_i.mode == MODE_FINE || sw_pend_q || prev_idle || !elig[active_q]) begin
      next_d     = pick_idx;
      next_vld_d = pick_found;
    end
  end

  assign do_pen    = next_vld_q && (cfg_i.mode != MODE_FINE) && (next_q != active_q);
  assign cycle_pen = cycle_q + (do_pen ? COUNT_WIDTH'(cfg_i.switch_penalty)
                                       : COUNT_WIDTH'(0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_THREADS; i++) begin
        ready_q[i] <= '0;
        pc_q[i]    <= '0;
      end
      halted_q    <= '0;
      active_q    <= '0;
      cycle_q     <= '0;
      issue_cnt_q <= '0;
      issued_q    <= 1'b0;
      sw_pend_q   <= 1'b0;
      started_q   <= 1'b0;
      kind_q      <= KIND_ALU;
      next_q      <= '0;
      next_vld_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_user_q  <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        kind_q <= kind_e'(kind_i);
      end
      if (cmd_i.apply && started_q && !all_halted) begin
        if (issued_q) begin
          case (kind_q)
            KIND_ALU: begin
              ready_q[active_q] <= cycle_q + COUNT_WIDTH'(1);
            end
            KIND_LOAD: begin
              ready_q[active_q] <= cycle_q + COUNT_WIDTH'(cfg_i.load_latency)
                                   + COUNT_WIDTH'(1);
              sw_pend_q <= 1'b1;
            end
            KIND_STORE: begin
              ready_q[active_q] <= cycle_q + COUNT_WIDTH'(cfg_i.store_latency)
                                   + COUNT_WIDTH'(1);
              sw_pend_q <= 1'b1;
            end
            default: begin
              halted_q[active_q] <= 1'b1;
              sw_pend_q          <= 1'b1;
            end
          endcase
        end
        cycle_q <= cycle_q + COUNT_WIDTH'(1);
      end
      if (cmd_i.pick) begin
        next_q     <= next_d;
        next_vld_q <= next_vld_d;
        sw_pend_q  <= 1'b0;
        started_q  <= 1'b1;
      end
      if (cmd_i.commit) begin
        out_user_q  <= next_vld_q;
        issued_q    <= next_vld_q;
        if (next_vld_q) begin
          cycle_q        <= cycle_pen;
          active_q       <= next_q;
          issue_cnt_q    <= issue_cnt_q + COUNT_WIDTH'(1);
          pc_q[next_q]   <= pc_q[next_q] + FIELD_W'(1);
          out_data_q     <= {PAD_W'(0),
                             FIELD_W'(issue_cnt_q + COUNT_WIDTH'(1)),
                             FIELD_W'(cycle_pen),
                             all_halted,
                             pc_q[next_q],
                             THREAD_FIELD_W'(next_q)};
        end else begin
          out_data_q     <= {PAD_W'(0),
                             FIELD_W'(issue_cnt_q),
                             FIELD_W'(cycle_q),
                             all_halted,
                             FIELD_W'(0),
                             THREAD_FIELD_W'(0)};
        end
      end
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_user_o     = out_user_q;
  assign out_data_o     = out_data_q;

endmodule

[design/multithread_issue_scheduler_core.sv]
// Multithread issue scheduler, top level: configuration registers,
// sequencer (mis_ctrl) and datapath (mis_dp). Depends on mis_pkg.
//
// Usage: each slave beat is one core cycle step; tdata[1:0] reports the
// kind of instruction the thread issued by the previous step ran (alu,
// load, store, halt). Each step yields exactly one master beat with the
// chosen thread, its PC, the all-done flag and the cycle and instruction
// counts; tuser is 1 when a thread issues in that step.
// Sequencing: each step passes through accept, apply the previous result,
// pick and commit in the four-state sequencer. A new slave beat is taken
// only once the previous step has committed, while the previous result may
// still wait in the output register.
// Stall: when the receiver holds tready low, the output beat holds, the next
// step waits in its commit state, and then no further slave beat is taken.
// Configuration: writes on the cfg channel are always taken (cfg_ready_o is
// tied high) and must happen only while no step is in flight.
// Reset: all thread state and counters clear, mode is blocked, two threads
// are in use; the first step issues thread 0.
module multithread_issue_scheduler_core #(
  parameter int MAX_THREADS = mis_pkg::MAX_THREADS_DEF,
  parameter int COUNT_WIDTH = mis_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // slave tdata: [1:0] last_kind, upper bits zero
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [mis_pkg::IN_TDATA_W-1:0]   s_axis_tdata_i,
  // master tdata: [2:0] issue_thread, [34:3] issue_pc, [35] all_done,
  //   [67:36] cycle_total, [99:68] instructions_total, upper bits zero
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [mis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  // master tuser: [0] issue_valid
  output logic                             m_axis_tuser_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [mis_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [mis_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mis_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode           <= 1'b0;
      cfg_q.thread_count   <= 4'd2;
      cfg_q.switch_penalty <= '0;
      cfg_q.load_latency   <= '0;
      cfg_q.store_latency  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MODE:           cfg_q.mode           <= cfg_data_i[0];
        CFG_THREAD_COUNT:   cfg_q.thread_count   <= cfg_data_i[3:0];
        CFG_SWITCH_PENALTY: cfg_q.switch_penalty <= cfg_data_i;
        CFG_LOAD_LATENCY:   cfg_q.load_latency   <= cfg_data_i;
        CFG_STORE_LATENCY:  cfg_q.store_latency  <= cfg_data_i;
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  mis_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mis_dp #(
    .MAX_THREADS (MAX_THREADS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .kind_i      (s_axis_tdata_i[KIND_W-1:0]),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .out_user_o  (m_axis_tuser_o),
    .out_data_o  (m_axis_tdata_o)
  );

endmodule

[design/mis_checker.sv]
// Port-level checker for the multithread issue scheduler, bound to the top.
// Depends on mis_pkg and multithread_issue_scheduler_core_defines.svh.
`include "multithread_issue_scheduler_core_defines.svh"

module mis_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [mis_pkg::OUT_TDATA_W-1:0]  m_axis_tdata_o,
  input logic                             m_axis_tuser_o
);
  import mis_pkg::*;

  // a stalled result beat holds its payload
  `MIS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i, m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o), "stalled beat changed")

  // once a slave beat is taken a step is in flight and tready drops
  `MIS_ASSERT_NXT(a_one_step, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o, "slave beat taken during a step")

  // an idle step reports thread and PC as zero
  `MIS_ASSERT_NOW(a_idle_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tuser_o, m_axis_tdata_o[34:0] == 35'd0, "idle beat with nonzero thread or pc")

  // nothing issues once every thread has halted
  `MIS_ASSERT_NOW(a_done_idle, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[35], !m_axis_tuser_o, "issue after all threads halted")

endmodule

bind multithread_issue_scheduler_core mis_checker u_mis_checker (.*);
